// ----- src/iapp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iapp_pkg - shared types and constants of the IMU angle packet parser
// Packet geometry, header codes, status codes and the record handed from
// the byte parser to the result stage.
// ----------------------------------------------------------------------------
package iapp_pkg;

	localparam int PACKET_BYTES = 33;
	localparam int FRAME_BYTES  = 11;

	localparam int COUNT_W     = 6;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int FULL_FRAMES = PACKET_BYTES / FRAME_BYTES;
	localparam int FRAME_W     = $clog2(FULL_FRAMES + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] PACKET_LEN = COUNT_W'(PACKET_BYTES);
	localparam logic [POS_W-1:0]   POS_CSUM   = POS_W'(FRAME_BYTES - 1);
	localparam logic [FRAME_W-1:0] FRAME_LIM  = FRAME_W'(FULL_FRAMES);

	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam logic [7:0] ANGLE_TYPE  = 8'h53;

	localparam int RAW_W   = 16;
	localparam int ANGLE_W = 24;
	localparam int N_AXES  = 3;

	// raw * 180 / 32768 degrees equals raw * 180 with 15 fraction bits
	localparam logic signed [ANGLE_W-1:0] DEG_SCALE = 24'sd180;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_LENGTH   = 2'd1,
		STATUS_NO_FRAME = 2'd2,
		STATUS_CHECKSUM = 2'd3
	} status_t;

	typedef struct packed {
		status_t                      status;
		logic [N_AXES-1:0][RAW_W-1:0] raw;
	} packet_rec_t;

endpackage
`default_nettype wire

// ----- src/iapp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iapp_if - stream channels of the IMU angle packet parser
// Byte input channel and angle result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iapp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface iapp_angle_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [23:0] roll_degrees;
	logic signed [23:0] pitch_degrees;
	logic signed [23:0] yaw_degrees;

	modport source (output valid, output status, output roll_degrees,
		output pitch_degrees, output yaw_degrees, input ready);
	modport sink   (input valid, input status, input roll_degrees,
		input pitch_degrees, input yaw_degrees, output ready);
endinterface
`default_nettype wire

// ----- src/iapp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iapp_front - byte parser
// Tracks position in packet and frame, checks the angle frame header and
// checksum, collects raw angles and pushes one record per packet.
// ----------------------------------------------------------------------------
module iapp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	iapp_byte_if.sink            bytes,
	input  logic                 full,
	output logic                 push,
	output iapp_pkg::packet_rec_t push_rec
);
	import iapp_pkg::*;

	logic [COUNT_W-1:0]           count_q, count_nx;
	logic [POS_W-1:0]             pos_q, pos_nx;
	logic [FRAME_W-1:0]           frame_q, frame_nx;
	logic [7:0]                   sum_q, sum_nx;
	logic                         match_q, match_nx;
	logic                         decided_q, decided_nx;
	status_t                      code_q, code_nx;
	logic [7:0]                   low_q, low_nx;
	logic [N_AXES-1:0][RAW_W-1:0] raw_q, raw_nx;
	logic                         accept, in_packet, parse_en;
	logic [POS_W-1:0]             pos_m3;
	logic [7:0]                   b;
	status_t                      status;

	assign bytes.ready = !full;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.byte_value;
	assign in_packet   = count_q < PACKET_LEN;
	assign parse_en    = !decided_q && in_packet && (frame_q < FRAME_LIM);
	assign pos_m3      = pos_q - POS_W'(3);

	always_comb begin
		count_nx   = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
		pos_nx     = pos_q;
		frame_nx   = frame_q;
		sum_nx     = sum_q;
		match_nx   = match_q;
		decided_nx = decided_q;
		code_nx    = code_q;
		low_nx     = low_q;
		raw_nx     = raw_q;

		if (in_packet) begin
			if (pos_q == POS_CSUM) begin
				pos_nx   = '0;
				frame_nx = frame_q + FRAME_W'(1);
			end else begin
				pos_nx = pos_q + POS_W'(1);
			end
		end

		if (parse_en) begin
			if (pos_q == '0) begin
				sum_nx   = b;
				match_nx = (b == HEADER_BYTE);
			end else if (pos_q == POS_CSUM) begin
				if (match_q) begin
					decided_nx = 1'b1;
					code_nx    = (sum_q == b) ? STATUS_OK : STATUS_CHECKSUM;
				end
			end else begin
				sum_nx = sum_q + b;
				if (pos_q == POS_W'(1)) begin
					match_nx = match_q && (b == ANGLE_TYPE);
				end else if (pos_q <= POS_W'(7)) begin
					if (!pos_q[0]) begin
						low_nx = b;
					end else begin
						// odd positions 3, 5, 7 close roll, pitch, yaw
						case (pos_m3[2:1])
							2'd0:    raw_nx[0] = {b, low_q};
							2'd1:    raw_nx[1] = {b, low_q};
							default: raw_nx[2] = {b, low_q};
						endcase
					end
				end
			end
		end
	end

	always_comb begin
		if (count_nx != PACKET_LEN) begin
			status = STATUS_LENGTH;
		end else if (!decided_nx) begin
			status = STATUS_NO_FRAME;
		end else begin
			status = code_nx;
		end
	end

	assign push            = accept && bytes.last_byte;
	assign push_rec.status = status;
	assign push_rec.raw    = raw_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pos_q     <= '0;
			frame_q   <= '0;
			sum_q     <= '0;
			match_q   <= 1'b0;
			decided_q <= 1'b0;
			code_q    <= STATUS_OK;
			low_q     <= '0;
			raw_q     <= '0;
		end else if (accept) begin
			raw_q <= raw_nx;
			if (bytes.last_byte) begin
				// drop all packet state but the raw angles
				count_q   <= '0;
				pos_q     <= '0;
				frame_q   <= '0;
				sum_q     <= '0;
				match_q   <= 1'b0;
				decided_q <= 1'b0;
				code_q    <= STATUS_OK;
				low_q     <= '0;
			end else begin
				count_q   <= count_nx;
				pos_q     <= pos_nx;
				frame_q   <= frame_nx;
				sum_q     <= sum_nx;
				match_q   <= match_nx;
				decided_q <= decided_nx;
				code_q    <= code_nx;
				low_q     <= low_nx;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/iapp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iapp_queue - packet record queue
// Short FIFO that decouples the byte parser from the result stage.
// ----------------------------------------------------------------------------
module iapp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  iapp_pkg::packet_rec_t push_rec,
	output logic                  full,
	output logic                  pop_valid,
	output iapp_pkg::packet_rec_t pop_rec,
	input  logic                  pop
);
	import iapp_pkg::*;

	packet_rec_t           mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	logic                  do_push, do_pop;

	assign full      = count_q == QUEUE_CW'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_rec   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QUEUE_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QUEUE_CW'(1);
				2'b01:   count_q <= count_q - QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/iapp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iapp_back - result stage
// Converts raw angles to degrees on success, holds the angles and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module iapp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	input  iapp_pkg::packet_rec_t rec,
	output logic                  pop,
	iapp_angle_if.source          angles
);
	import iapp_pkg::*;

	logic signed [ANGLE_W-1:0] held_q   [N_AXES];
	logic signed [ANGLE_W-1:0] held_nx  [N_AXES];
	logic signed [ANGLE_W-1:0] raw_ext  [N_AXES];
	logic                      valid_q;
	status_t                   status_q;
	logic signed [ANGLE_W-1:0] roll_q, pitch_q, yaw_q;

	assign pop = rec_valid && (!valid_q || angles.ready);

	always_comb begin
		for (int k = 0; k < N_AXES; k++) begin
			raw_ext[k] = {{(ANGLE_W - RAW_W){rec.raw[k][RAW_W-1]}}, rec.raw[k]};
			held_nx[k] = (rec.status == STATUS_OK) ? raw_ext[k] * DEG_SCALE : held_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			for (int k = 0; k < N_AXES; k++) begin
				held_q[k] <= '0;
			end
		end else if (pop) begin
			valid_q <= 1'b1;
			for (int k = 0; k < N_AXES; k++) begin
				held_q[k] <= held_nx[k];
			end
		end else if (angles.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= rec.status;
			roll_q   <= held_nx[0];
			pitch_q  <= held_nx[1];
			yaw_q    <= held_nx[2];
		end
	end

	assign angles.valid         = valid_q;
	assign angles.status        = status_q;
	assign angles.roll_degrees  = roll_q;
	assign angles.pitch_degrees = pitch_q;
	assign angles.yaw_degrees   = yaw_q;

endmodule
`default_nettype wire

// ----- src/imu_angle_packet_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// imu_angle_packet_parser - IMU angle packet parser, top level
// Byte parser, record queue and result stage.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle on bytes while bytes.ready is high; the byte
// flagged last_byte ends the packet and yields one result on angles: a status
// and the held roll, pitch and yaw in degrees, signed with 15 fraction bits. The
// first frame of the packet starting 0x55 0x53 decides; held angles change only
// on success. Throughput is one byte per cycle while the record queue has room;
// a result passes through the record queue and then the result registers.
// bytes.ready drops only when the two-entry record queue is full because angles
// is stalled. No clearing pass is needed after reset.
module imu_angle_packet_parser (
	input  logic         clk,
	input  logic         arst_n,
	iapp_byte_if.sink    bytes,
	iapp_angle_if.source angles
);
	import iapp_pkg::*;

	logic        push, full, rec_valid, pop;
	packet_rec_t push_rec, pop_rec;

	iapp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.full     (full),
		.push     (push),
		.push_rec (push_rec)
	);

	iapp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (full),
		.pop_valid (rec_valid),
		.pop_rec   (pop_rec),
		.pop       (pop)
	);

	iapp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (pop_rec),
		.pop       (pop),
		.angles    (angles)
	);

endmodule
`default_nettype wire
